// ===== src/heo_pkg.sv =====
// ----------------------------------------------------------------------------
// heo_pkg
// Shared types, codes and fixed-point helpers of the hall encoder odometry.
// ----------------------------------------------------------------------------
package heo_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int POS_BITS   = 32;
    localparam int PHASE_BITS = 24;
    localparam int QDEPTH     = 2;
    localparam int POS_OUT_W  = (POS_BITS > 32) ? POS_BITS : 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // request codes on the input channel
    localparam logic [1:0] REQ_SAMPLE = 2'd0;
    localparam logic [1:0] REQ_SETPOS = 2'd1;
    localparam logic [1:0] REQ_RESET  = 2'd2;

    // command codes in the queue
    localparam logic [1:0] CMD_STEP    = 2'd0;
    localparam logic [1:0] CMD_SETPOS  = 2'd1;
    localparam logic [1:0] CMD_RSTSTEP = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HALF   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AXLE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REV    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STABLE = 3'd4;

    localparam logic [PHASE_BITS-1:0] PHASE_LSB_MASK =
        PHASE_BITS'((1 << (PHASE_BITS - ANGLE_BITS)) - 1);
    localparam logic [PHASE_BITS-1:0] QUARTER_TURN = 24'h40_0000;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [15:0]        heading;
        logic [15:0]        steer;
        logic [31:0]        time_us;
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
    } t_cmd_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic [19:0] half_circ;
        logic [13:0] axle;
        logic        reversed;
        logic [15:0] heading_offset;
    } t_back_cfg;

    function automatic logic [PHASE_BITS-1:0] to_phase(logic [15:0] angle);
        logic [PHASE_BITS-1:0] p;
        p = {angle, 8'h00};
        return p & ~PHASE_LSB_MASK;
    endfunction

    function automatic logic [31:0] pos_out(logic [POS_BITS-1:0] a);
        logic [POS_OUT_W-1:0] e;
        e = POS_OUT_W'(signed'(a));
        return e[31:0];
    endfunction

endpackage

// ===== src/hall_encoder_odometry_top.sv =====
// ----------------------------------------------------------------------------
// hall_encoder_odometry_top
// Hall-sensor wheel odometry with heading projection, velocity and yaw rate.
// ----------------------------------------------------------------------------
// Input channel (i_valid/o_ready) carries a sensor sample, a set-position or a
// reset-distance request. Samples are debounced in the front end; a counted
// wheel step, a reset-distance request and a set-position request go into a
// two-entry command queue, so the front keeps taking items while the back
// end works and drops o_ready only when two commands wait. Each counted step
// or reset-distance request gives one transfer on the result channel
// (o_valid/i_ready): distance, x/y position, velocity, yaw rate, stopped.
// A sample that counts no step is not queued; set position is applied in the
// cycle after it is taken when the back end is idle, else behind the queued
// steps, and gives no result.
// With the back end idle, a counted step makes three passes of the shared sine
// unit (cosine and sine of the heading, sine of the steering), then runs the
// serial divider for the yaw rate before it shows on o_valid; the velocity
// division overlaps the sine work. The back end works on one step at a time.
// A finished result waits in the output register while the back end goes on
// with the next command; the back end holds its final step only when that
// register is still full. Synchronous reset restores the register defaults,
// clears position, distance and the debounce, and empties the queue.
// ----------------------------------------------------------------------------
module hall_encoder_odometry_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [heo_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [heo_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [1:0]                       i_req_type,
    input  logic                             i_hall_level,
    input  logic [15:0]                      i_heading,
    input  logic [15:0]                      i_steer_angle,
    input  logic [31:0]                      i_time_us,
    input  logic signed [31:0]               i_new_x,
    input  logic signed [31:0]               i_new_y,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [31:0]               o_distance_um,
    output logic signed [31:0]               o_pos_x,
    output logic signed [31:0]               o_pos_y,
    output logic signed [31:0]               o_velocity_mm_s,
    output logic signed [31:0]               o_angular_velocity_mrad_s,
    output logic                             o_stopped
);
    import heo_pkg::*;

    logic [19:0] r_half;
    logic [13:0] r_axle;
    logic        r_rev;
    logic [15:0] r_offset;
    logic [7:0]  r_stable;

    t_back_cfg   back_cfg;
    t_q_stat     q_stat;
    t_cmd_item   push_item, head_item;
    logic        push, pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half   <= 20'd180642;
            r_axle   <= 14'd280;
            r_rev    <= 1'b0;
            r_offset <= 16'd0;
            r_stable <= 8'd10;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HALF:   r_half   <= i_cfg_data;
                CFG_AXLE:   r_axle   <= i_cfg_data[13:0];
                CFG_REV:    r_rev    <= i_cfg_data[0];
                CFG_OFFSET: r_offset <= i_cfg_data[15:0];
                CFG_STABLE: r_stable <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    assign back_cfg.half_circ      = r_half;
    assign back_cfg.axle           = r_axle;
    assign back_cfg.reversed       = r_rev;
    assign back_cfg.heading_offset = r_offset;

    heo_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_stable_samples (r_stable),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_req_type       (i_req_type),
        .i_hall_level     (i_hall_level),
        .i_heading        (i_heading),
        .i_steer_angle    (i_steer_angle),
        .i_time_us        (i_time_us),
        .i_new_x          (i_new_x),
        .i_new_y          (i_new_y),
        .i_stat           (q_stat),
        .o_push           (push),
        .o_item           (push_item)
    );

    heo_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_stat  (q_stat)
    );

    heo_back u_back (
        .i_clk                     (i_clk),
        .i_rst_n                   (i_rst_n),
        .i_cfg                     (back_cfg),
        .i_item                    (head_item),
        .i_stat                    (q_stat),
        .o_pop                     (pop),
        .o_valid                   (o_valid),
        .i_ready                   (i_ready),
        .o_distance_um             (o_distance_um),
        .o_pos_x                   (o_pos_x),
        .o_pos_y                   (o_pos_y),
        .o_velocity_mm_s           (o_velocity_mm_s),
        .o_angular_velocity_mrad_s (o_angular_velocity_mrad_s),
        .o_stopped                 (o_stopped)
    );

endmodule

// ===== src/heo_front.sv =====
// ----------------------------------------------------------------------------
// heo_front
// Accepts items, runs the hall debounce and queues commands for the back end.
// ----------------------------------------------------------------------------
module heo_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [7:0]         i_stable_samples,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_req_type,
    input  logic               i_hall_level,
    input  logic [15:0]        i_heading,
    input  logic [15:0]        i_steer_angle,
    input  logic [31:0]        i_time_us,
    input  logic signed [31:0] i_new_x,
    input  logic signed [31:0] i_new_y,
    input  heo_pkg::t_q_stat   i_stat,
    output logic               o_push,
    output heo_pkg::t_cmd_item o_item
);
    import heo_pkg::*;

    logic       r_expected, n_expected;
    logic [7:0] r_match, n_match;
    logic [7:0] bump;
    logic       accept;

    assign o_ready = !i_stat.full;
    assign accept  = i_valid && o_ready;
    assign bump    = (r_match != 8'hFF) ? r_match + 8'd1 : r_match;

    always_comb begin
        n_expected     = r_expected;
        n_match        = r_match;
        o_push         = 1'b0;
        o_item.cmd     = CMD_STEP;
        o_item.heading = i_heading;
        o_item.steer   = i_steer_angle;
        o_item.time_us = i_time_us;
        o_item.new_x   = i_new_x;
        o_item.new_y   = i_new_y;
        if (accept) begin
            unique case (i_req_type)
                REQ_SETPOS: begin
                    o_push     = 1'b1;
                    o_item.cmd = CMD_SETPOS;
                end
                REQ_RESET: begin
                    o_push     = 1'b1;
                    o_item.cmd = CMD_RSTSTEP;
                    n_expected = !r_expected;
                    n_match    = 8'd0;
                end
                REQ_SAMPLE: begin
                    if (i_hall_level != r_expected) begin
                        n_match = 8'd0;
                    end else if (bump >= i_stable_samples) begin
                        o_push     = 1'b1;
                        n_expected = !r_expected;
                        n_match    = 8'd0;
                    end else begin
                        n_match = bump;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected <= 1'b1;
            r_match    <= 8'd0;
        end else begin
            r_expected <= n_expected;
            r_match    <= n_match;
        end
    end

endmodule

// ===== src/heo_fifo.sv =====
// ----------------------------------------------------------------------------
// heo_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module heo_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  heo_pkg::t_cmd_item i_item,
    input  logic               i_pop,
    output heo_pkg::t_cmd_item o_item,
    output heo_pkg::t_q_stat   o_stat
);
    import heo_pkg::*;

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    t_cmd_item       r_mem [QDEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [CW-1:0]   r_count;

    assign o_item       = r_mem[r_rp];
    assign o_stat.full  = (r_count == CW'(QDEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(QDEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(QDEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QDEPTH))
        else $error("queue count beyond depth");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("pop from empty queue");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> r_count != CW'(QDEPTH))
        else $error("push into full queue");

endmodule

// ===== src/heo_sin.sv =====
// ----------------------------------------------------------------------------
// heo_sin
// Iterative Q30 sine of a 24-bit phase on one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module heo_sin (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [heo_pkg::PHASE_BITS-1:0] i_phase,
    output logic                           o_done,
    output logic [30:0]                    o_mag,
    output logic                           o_neg
);
    import heo_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_T    = 4'd1;
    localparam logic [3:0] S_T2   = 4'd2;
    localparam logic [3:0] S_T3   = 4'd3;
    localparam logic [3:0] S_A    = 4'd4;
    localparam logic [3:0] S_B    = 4'd5;
    localparam logic [3:0] S_C    = 4'd6;
    localparam logic [3:0] S_D    = 4'd7;
    localparam logic [3:0] S_F    = 4'd8;

    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
    localparam logic [31:0] Q30_ONE     = 32'h4000_0000;

    logic [3:0]  r_state;
    logic        r_done;
    logic [22:0] r_r;
    logic [31:0] r_t;
    logic [31:0] r_t2;
    logic [31:0] r_term;
    logic [30:0] r_acc;
    logic [2:0]  r_i;
    logic [63:0] r_prod;
    logic [30:0] r_mag;
    logic        r_neg;

    logic [31:0] mul_a, mul_b;
    logic [6:0]  k_now;
    logic [31:0] m_now;
    logic [31:0] qe, rem, qfix, sres;
    logic [22:0] r_in;

    // series divisors and their floor(2^32/k) reciprocals
    always_comb begin
        unique case (r_i)
            3'd0:    begin k_now = 7'd110; m_now = 32'd39045157;  end
            3'd1:    begin k_now = 7'd72;  m_now = 32'd59652323;  end
            3'd2:    begin k_now = 7'd42;  m_now = 32'd102261126; end
            3'd3:    begin k_now = 7'd20;  m_now = 32'd214748364; end
            default: begin k_now = 7'd6;   m_now = 32'd715827882; end
        endcase
    end

    always_comb begin
        unique case (r_state)
            S_T:     begin mul_a = {9'b0, r_r};        mul_b = HALF_PI_Q30;     end
            S_T2:    begin mul_a = r_prod[53:22];      mul_b = r_prod[53:22];   end
            S_A:     begin mul_a = r_t2;               mul_b = {1'b0, r_acc};   end
            S_B:     begin mul_a = r_prod[61:30];      mul_b = m_now;           end
            S_D:     begin mul_a = r_t;                mul_b = {1'b0, r_acc};   end
            default: begin mul_a = 32'd0;              mul_b = 32'd0;           end
        endcase
    end

    // reciprocal estimate is at most one short
    assign qe   = r_prod[63:32];
    assign rem  = r_term - qe * {25'b0, k_now};
    assign qfix = (rem >= {25'b0, k_now}) ? qe + 32'd1 : qe;
    assign sres = r_prod[61:30];
    assign r_in = i_phase[22] ? 23'h40_0000 - {1'b0, i_phase[21:0]} : {1'b0, i_phase[21:0]};

    always_ff @(posedge i_clk) begin
        r_prod <= {32'b0, mul_a} * {32'b0, mul_b};
        unique case (r_state)
            S_IDLE: begin
                r_r   <= r_in;
                r_neg <= i_phase[23];
            end
            S_T2: r_t <= r_prod[53:22];
            S_T3: begin
                r_t2  <= r_prod[61:30];
                r_acc <= Q30_ONE[30:0];
                r_i   <= 3'd0;
            end
            S_B: r_term <= r_prod[61:30];
            S_C: begin
                r_acc <= 31'(Q30_ONE - qfix);
                r_i   <= r_i + 3'd1;
            end
            S_F: r_mag <= (sres > Q30_ONE) ? Q30_ONE[30:0] : sres[30:0];
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == S_F);
            unique case (r_state)
                S_IDLE:  if (i_start) r_state <= S_T;
                S_T:     r_state <= S_T2;
                S_T2:    r_state <= S_T3;
                S_T3:    r_state <= S_A;
                S_A:     r_state <= S_B;
                S_B:     r_state <= S_C;
                S_C:     r_state <= (r_i == 3'd4) ? S_D : S_A;
                S_D:     r_state <= S_F;
                S_F:     r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_mag  = r_mag;
    assign o_neg  = r_neg;

    a_mag_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_mag <= Q30_ONE[30:0])
        else $error("sine magnitude above one");

endmodule

// ===== src/heo_div.sv =====
// ----------------------------------------------------------------------------
// heo_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module heo_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [43:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_busy,
    output logic [43:0] o_quo
);
    import heo_pkg::*;

    localparam int DW = 44;
    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [31:0]   r_rem;
    logic [31:0]   r_den;
    logic [DW-1:0] r_quo;
    logic [32:0]   sh;
    logic          fit;

    assign sh  = {r_rem, r_quo[DW-1]};
    assign fit = (sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_rem <= 32'd0;
            r_den <= i_den;
            r_quo <= i_num;
        end else if (r_busy) begin
            r_rem <= fit ? 32'(sh - {1'b0, r_den}) : sh[31:0];
            r_quo <= {r_quo[DW-2:0], fit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start && !r_busy) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(DW);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - CW'(1);
            r_busy <= (r_cnt != CW'(1));
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

endmodule

// ===== src/heo_back.sv =====
// ----------------------------------------------------------------------------
// heo_back
// Executes queued commands: projections, velocity, yaw rate and accumulators.
// ----------------------------------------------------------------------------
module heo_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  heo_pkg::t_back_cfg  i_cfg,
    input  heo_pkg::t_cmd_item  i_item,
    input  heo_pkg::t_q_stat    i_stat,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [31:0]  o_distance_um,
    output logic signed [31:0]  o_pos_x,
    output logic signed [31:0]  o_pos_y,
    output logic signed [31:0]  o_velocity_mm_s,
    output logic signed [31:0]  o_angular_velocity_mrad_s,
    output logic                o_stopped
);
    import heo_pkg::*;

    localparam logic [3:0] B_IDLE = 4'd0;
    localparam logic [3:0] B_COS  = 4'd1;
    localparam logic [3:0] B_SIN  = 4'd2;
    localparam logic [3:0] B_STR  = 4'd3;
    localparam logic [3:0] B_PX   = 4'd4;
    localparam logic [3:0] B_PY   = 4'd5;
    localparam logic [3:0] B_VEL  = 4'd6;
    localparam logic [3:0] B_W1   = 4'd7;
    localparam logic [3:0] B_W2   = 4'd8;
    localparam logic [3:0] B_W3   = 4'd9;
    localparam logic [3:0] B_WD   = 4'd10;
    localparam logic [3:0] B_FIN  = 4'd11;

    logic [3:0]            r_state;
    logic                  r_valid;
    logic [POS_BITS-1:0]   r_x, r_y;
    logic [31:0]           r_trav;
    logic [31:0]           r_last_time;

    logic                  r_rst;
    logic [PHASE_BITS-1:0] r_hph;
    logic [15:0]           r_steer;
    logic [31:0]           r_dt;
    logic [30:0]           r_cmag, r_smag;
    logic                  r_cneg, r_sneg, r_steer_neg;
    logic [16:0]           r_s16;
    logic [50:0]           r_prod;
    logic [POS_BITS-1:0]   r_dx, r_dy;
    logic [31:0]           r_v, r_vmag;
    logic                  r_vneg;
    logic [48:0]           r_p1;
    logic [58:0]           r_num;
    logic [31:0]           r_w;

    logic [31:0]           r_out_dist, r_out_px, r_out_py, r_out_v, r_out_w;
    logic                  r_out_stop;

    logic                  sin_start, sin_done, sin_neg;
    logic [PHASE_BITS-1:0] sin_phase;
    logic [30:0]           sin_mag;
    logic                  div_start, div_busy;
    logic [43:0]           div_num, div_quo;
    logic [31:0]           div_den;

    logic [PHASE_BITS-1:0] pop_hph;
    logic [20:0]           proj;
    logic [POS_BITS-1:0]   proj_s;
    logic                  ds_zero, ds_neg;
    logic [31:0]           ds32, trav_new, vq;
    logic [POS_BITS-1:0]   x_new, y_new;
    logic [43:0]           wmag;
    logic                  wneg;
    logic                  load, take;

    heo_sin u_sin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sin_start),
        .i_phase (sin_phase),
        .o_done  (sin_done),
        .o_mag   (sin_mag),
        .o_neg   (sin_neg)
    );

    heo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quo   (div_quo)
    );

    assign pop_hph = to_phase(i_item.heading - i_cfg.heading_offset);
    assign ds_zero = (i_cfg.half_circ == 20'd0);
    assign ds_neg  = i_cfg.reversed && !ds_zero;
    assign ds32    = i_cfg.reversed ? -{12'b0, i_cfg.half_circ} : {12'b0, i_cfg.half_circ};
    assign proj    = 21'((r_prod + 51'h2000_0000) >> 30);
    assign proj_s  = POS_BITS'(proj);
    assign vq      = div_quo[31:0];
    assign trav_new = (r_rst ? 32'd0 : r_trav) + ds32;
    assign x_new   = r_x + r_dx;
    assign y_new   = r_y + r_dy;
    assign wneg    = r_vneg != r_steer_neg;
    assign take    = r_valid && i_ready;
    assign load    = (r_state == B_FIN) && (!r_valid || i_ready);
    assign o_pop   = (r_state == B_IDLE) && !i_stat.empty;

    always_comb begin
        if (i_cfg.axle == 14'd0) begin
            wmag = (r_num != 59'd0) ? 44'h0_8000_0000 : 44'd0;
        end else begin
            wmag = div_quo;
        end
    end

    always_comb begin
        sin_start = 1'b0;
        sin_phase = r_hph;
        div_start = 1'b0;
        div_num   = 44'(r_num[58:16]);
        div_den   = {18'b0, i_cfg.axle};
        unique case (r_state)
            B_IDLE: begin
                if (o_pop && (i_item.cmd != CMD_SETPOS)) begin
                    sin_start = 1'b1;
                    sin_phase = pop_hph + QUARTER_TURN;
                    div_start = 1'b1;
                    div_num   = 44'({12'b0, i_cfg.half_circ} * 32'd1000);
                    div_den   = i_item.time_us - r_last_time;
                end
            end
            B_COS: begin
                sin_start = sin_done;
                sin_phase = r_hph;
            end
            B_SIN: begin
                sin_start = sin_done;
                sin_phase = to_phase(r_steer);
            end
            B_W3: div_start = 1'b1;
            default: begin
            end
        endcase
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                r_hph   <= pop_hph;
                r_steer <= i_item.steer;
                r_rst   <= (i_item.cmd == CMD_RSTSTEP);
                r_dt    <= i_item.time_us - r_last_time;
            end
            B_COS: if (sin_done) begin
                r_cmag <= sin_mag;
                r_cneg <= sin_neg;
            end
            B_SIN: if (sin_done) begin
                r_smag <= sin_mag;
                r_sneg <= sin_neg;
            end
            B_STR: if (sin_done) begin
                r_s16       <= 17'((32'(sin_mag) + 32'd8192) >> 14);
                r_steer_neg <= sin_neg;
                r_prod      <= {31'b0, i_cfg.half_circ} * {20'b0, r_cmag};
            end
            B_PX: begin
                r_dx   <= (r_cneg ^ i_cfg.reversed) ? -proj_s : proj_s;
                r_prod <= {31'b0, i_cfg.half_circ} * {20'b0, r_smag};
            end
            B_PY: r_dy <= (r_sneg ^ i_cfg.reversed) ? -proj_s : proj_s;
            B_VEL: if (!div_busy) begin
                if (r_dt == 32'd0) begin
                    r_vmag <= ds_zero ? 32'd0 : (ds_neg ? 32'h8000_0000 : 32'h7FFF_FFFF);
                    r_v    <= ds_zero ? 32'd0 : (ds_neg ? 32'h8000_0000 : 32'h7FFF_FFFF);
                end else begin
                    r_vmag <= vq;
                    r_v    <= ds_neg ? -vq : vq;
                end
                r_vneg <= ds_neg && (r_dt != 32'd0 || !ds_zero) && !(r_dt != 32'd0 && vq == 32'd0);
            end
            B_W1: r_p1  <= {17'b0, r_vmag} * {32'b0, r_s16};
            B_W2: r_num <= {10'b0, r_p1} * 59'd1000;
            B_WD: if (!div_busy) begin
                if (wneg) begin
                    r_w <= (wmag > 44'h0_8000_0000) ? 32'h8000_0000 : -wmag[31:0];
                end else begin
                    r_w <= (wmag > 44'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : wmag[31:0];
                end
            end
            default: begin
            end
        endcase
        if (load) begin
            r_out_dist <= trav_new;
            r_out_px   <= pos_out(x_new);
            r_out_py   <= pos_out(y_new);
            r_out_v    <= r_v;
            r_out_w    <= r_w;
            r_out_stop <= (r_v == 32'd0);
        end
    end

    // control and accumulator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_valid     <= 1'b0;
            r_x         <= '0;
            r_y         <= '0;
            r_trav      <= 32'd0;
            r_last_time <= 32'd0;
        end else begin
            // a new result may replace the one taken in the same cycle
            if (take && !load) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (o_pop) begin
                        if (i_item.cmd == CMD_SETPOS) begin
                            r_x <= POS_BITS'(i_item.new_x);
                            r_y <= POS_BITS'(i_item.new_y);
                        end else begin
                            r_last_time <= i_item.time_us;
                            r_state     <= B_COS;
                        end
                    end
                end
                B_COS:   if (sin_done) r_state <= B_SIN;
                B_SIN:   if (sin_done) r_state <= B_STR;
                B_STR:   if (sin_done) r_state <= B_PX;
                B_PX:    r_state <= B_PY;
                B_PY:    r_state <= B_VEL;
                B_VEL:   if (!div_busy) r_state <= B_W1;
                B_W1:    r_state <= B_W2;
                B_W2:    r_state <= B_W3;
                B_W3:    r_state <= B_WD;
                B_WD:    if (!div_busy) r_state <= B_FIN;
                B_FIN: begin
                    if (load) begin
                        r_trav  <= trav_new;
                        r_x     <= x_new;
                        r_y     <= y_new;
                        r_valid <= 1'b1;
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_valid                   = r_valid;
    assign o_distance_um             = r_out_dist;
    assign o_pos_x                   = r_out_px;
    assign o_pos_y                   = r_out_py;
    assign o_velocity_mm_s           = r_out_v;
    assign o_angular_velocity_mrad_s = r_out_w;
    assign o_stopped                 = r_out_stop;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_distance_um) && $stable(o_pos_x)
            && $stable(o_velocity_mm_s))
        else $error("result changed while waiting");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_stat.empty && r_state == B_IDLE)
        else $error("pop outside idle");

endmodule
